FILE: rtl/bvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_pkg: shared types and constants of the bounded vector store
// Holds the word types of both channels, the operation codes, the controller
// states and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bvs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_PUSH_ZERO = 3'd1,
        OP_POP       = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
        logic [3:0]  index;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [31:0] popped_value;
        logic [4:0]  count;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_WAIT,
        ST_RM_RD,
        ST_RM_WR,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic res_init;
        logic res_ok;
        logic wr_push;
        logic rd_pop;
        logic cap_pop;
        logic ptr_init;
        logic rd_rm;
        logic wr_rm;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_remove;
        logic is_clear;
        logic full;
        logic empty;
        logic idx_in;
        logic idx_last;
        logic rm_more;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/bounded_vector_store_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_vector_store_top: bounded vector store with push, pop and remove
// A fixed-capacity vector of elements kept in one RAM, operated on one word
// at a time, with one result word for every operation word.
// ----------------------------------------------------------------------------
// One operation word is taken at a time. Push, push-zero, clear, a failed pop
// and a remove that needs no shifting pass through execute and done states
// back to idle; a successful pop adds a read-wait state, because the element
// comes from the registered read port of the RAM. A remove at index k on a
// store of n elements moves the n-1-k elements above k down one at a time
// through the single read and write port, each move being
// a read state and then a write state. The result word sits in an output
// register, so the block returns to accepting new words while a finished
// result still waits to be taken; only a second result blocks on a stalled
// output. A pop returns the last element, truncated or zero-extended to the
// 32-bit field; a push on a full store and a pop on an empty one report
// ok low and leave the store as it was. Entries above the count are never
// read, so the RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module bounded_vector_store_top #(
    parameter int DEPTH      = bvs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bvs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bvs_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bvs_pkg::t_out_word      o_out_word
);

    import bvs_pkg::*;

    // Command and status groups between sequencer and datapath.
    t_cmd cmd;
    t_sts sts;

    // The sequencer owns the input handshake: a word is taken only in idle.
    bvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the element RAM, the count and the output register.
    bvs_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // Once a word is taken, the block is busy on the next cycle.
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while previous operation still running");

    // A new result is only produced while an operation is in progress.
    a_result_from_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an operation in progress");

    // A nonzero popped element only comes with a successful operation.
    a_pop_implies_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.popped_value != '0)) |-> o_out_word.ok)
        else $error("popped element reported on a failed operation");

    // A result is loaded only when the output register is empty or being read.
    a_load_needs_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

FILE: rtl/bvs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/bvs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_ctrl: operation sequencer of the bounded vector store
// Steps each accepted operation through execute, read wait, shift loop and
// result hand-off, driving the datapath by commands.
// ----------------------------------------------------------------------------
module bvs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire bvs_pkg::t_sts i_sts,
    output bvs_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    import bvs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.res_init = 1'b1;
                n_state        = ST_DONE;
                if (i_sts.is_push) begin
                    if (!i_sts.full) begin
                        o_cmd.res_ok  = 1'b1;
                        o_cmd.wr_push = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end else if (i_sts.is_pop) begin
                    if (!i_sts.empty) begin
                        o_cmd.res_ok  = 1'b1;
                        o_cmd.rd_pop  = 1'b1;
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = ST_POP_WAIT;
                    end
                end else if (i_sts.is_remove) begin
                    o_cmd.res_ok = 1'b1;
                    if (i_sts.idx_in) begin
                        o_cmd.ptr_init = 1'b1;
                        if (i_sts.idx_last) begin
                            o_cmd.cnt_dec = 1'b1;
                        end else begin
                            n_state = ST_RM_RD;
                        end
                    end
                end else if (i_sts.is_clear) begin
                    o_cmd.res_ok  = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                end
            end
            ST_POP_WAIT: begin
                o_cmd.cap_pop = 1'b1;
                n_state       = ST_DONE;
            end
            ST_RM_RD: begin
                o_cmd.rd_rm = 1'b1;
                n_state     = ST_RM_WR;
            end
            ST_RM_WR: begin
                o_cmd.wr_rm = 1'b1;
                if (i_sts.rm_more) begin
                    n_state = ST_RM_RD;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/bvs_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_dpath: storage and arithmetic of the bounded vector store
// Holds the element RAM, the fill count, the shift pointer, the latched
// operation and the output word register.
// ----------------------------------------------------------------------------
module bvs_dpath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bvs_pkg::t_in_word i_in_word,
    input  wire bvs_pkg::t_cmd     i_cmd,
    input  wire logic              i_out_stall,
    output bvs_pkg::t_sts          o_sts,
    output logic                   o_out_valid,
    output bvs_pkg::t_out_word     o_out_word
);

    import bvs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [2:0]            r_op;
    logic [31:0]           r_value;
    logic [3:0]            r_idx;
    logic [CW-1:0]         r_fill;
    logic [AW-1:0]         r_ptr;
    logic                  r_res_ok;
    logic [31:0]           r_res_pop;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [AW-1:0]         fill_addr;
    logic [AW-1:0]         last_addr;
    logic [AW-1:0]         idx_addr;
    logic [63:0]           value_wide;
    logic [63:0]           rdata_wide;
    logic [63:0]           idx_wide;
    logic [63:0]           fill_wide;
    logic [DATA_WIDTH-1:0] push_data;

    // Width adaption between the fixed word fields and the parameterized store.
    assign value_wide = 64'(r_value);
    assign rdata_wide = 64'(ram_rdata);
    assign idx_wide   = 64'(r_idx);
    assign fill_wide  = 64'(r_fill);
    assign fill_addr  = fill_wide[AW-1:0];
    assign last_addr  = fill_addr - AW'(1);
    assign idx_addr   = idx_wide[AW-1:0];
    assign push_data  = (r_op == OP_PUSH) ? value_wide[DATA_WIDTH-1:0] : '0;

    always_comb begin
        o_sts           = '0;
        o_sts.is_push   = (r_op == OP_PUSH) || (r_op == OP_PUSH_ZERO);
        o_sts.is_pop    = (r_op == OP_POP);
        o_sts.is_remove = (r_op == OP_REMOVE);
        o_sts.is_clear  = (r_op == OP_CLEAR);
        o_sts.full      = (r_fill == CW'(DEPTH));
        o_sts.empty     = (r_fill == '0);
        o_sts.idx_in    = (32'(r_idx) < 32'(r_fill));
        o_sts.idx_last  = ((32'(r_idx) + 32'd1) >= 32'(r_fill));
        o_sts.rm_more   = ((32'(r_ptr) + 32'd2) < 32'(r_fill));
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        ram_we    = i_cmd.wr_push || i_cmd.wr_rm;
        ram_waddr = i_cmd.wr_push ? fill_addr : r_ptr;
        ram_wdata = i_cmd.wr_push ? push_data : ram_rdata;
        ram_raddr = i_cmd.rd_pop ? last_addr : (r_ptr + AW'(1));
    end

    bvs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= i_in_word.operation;
            r_value <= i_in_word.value;
            r_idx   <= i_in_word.index;
        end
        if (i_cmd.ptr_init) begin
            r_ptr <= idx_addr;
        end else if (i_cmd.wr_rm) begin
            r_ptr <= r_ptr + AW'(1);
        end
        if (i_cmd.res_init) begin
            r_res_ok  <= i_cmd.res_ok;
            r_res_pop <= '0;
        end else if (i_cmd.cap_pop) begin
            r_res_pop <= rdata_wide[31:0];
        end
        if (i_cmd.load_out) begin
            r_out_word.ok           <= r_res_ok;
            r_out_word.popped_value <= r_res_pop;
            r_out_word.count        <= fill_wide[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_fill <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_fill <= r_fill - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire
